@@ rtl/tass_pkg.sv @@
// Package: types and codes for the timed action slot scheduler.
`timescale 1ns / 1ps
`default_nettype none
package tass_pkg;
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SCHED = 2'd1,
        OP_DESCH = 2'd2,
        OP_STOP  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_TICK  = 2'd1,
        EV_STOP  = 2'd2,
        EV_DONE  = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SCHED = 2'd1,
        PH_RUN   = 2'd2,
        PH_PEND  = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_LOAD,
        ST_IVL,
        ST_RAN,
        ST_OFS,
        ST_DUR,
        ST_EMIT,
        ST_NEXT,
        ST_CLEAR,
        ST_DONE,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

@@ rtl/timed_action_slot_scheduler.sv @@
// Top level: timed action slot scheduler with a shared subtract/compare unit.
//
// Input channel (i_valid/o_ready) takes one command item: tick, schedule,
// deschedule or stop request. Output channel (o_valid/i_ready) returns the
// events of that item, one per item on the port, the final one with o_last.
// A command other than a tick passes the load and command states, then
// the done state and the output handshake. A tick walks every slot in
// slot order through one shared subtractor/comparator: a scheduled slot
// takes the interval and run-time checks, then a start or the offset and
// duration checks, then any events; idle slots are skipped; a clear pass.
// One item is in work at a time; o_ready is low until its last event is
// taken. A stalled receiver holds the current event in the output register
// and the walk waits for it. Reset clears every slot to not scheduled, all
// slot times and flags to zero, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module timed_action_slot_scheduler #(
    parameter int NUM_SLOTS = 8,
    parameter int TIME_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [2:0]  i_slot,
    input  wire logic [31:0] i_now,
    input  wire logic [31:0] i_interval,
    input  wire logic [31:0] i_duration,
    input  wire logic [31:0] i_tick_after,
    input  wire logic        i_repeat_req,
    input  wire logic [7:0]  i_permit_mask,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_event_res,
    output logic [2:0]       o_event_slot,
    output logic             o_ok,
    output logic             o_last
);
    import tass_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TW = TIME_BITS;

    t_phase          r_phase [NUM_SLOTS];
    logic            r_stopf [NUM_SLOTS];
    logic            r_rep   [NUM_SLOTS];
    logic            r_clr   [NUM_SLOTS];
    logic [TW-1:0]   r_ivl   [NUM_SLOTS];
    logic [TW-1:0]   r_dur   [NUM_SLOTS];
    logic [TW-1:0]   r_ofs   [NUM_SLOTS];
    logic [TW-1:0]   r_start [NUM_SLOTS];
    logic [TW-1:0]   r_stopt [NUM_SLOTS];

    t_state          r_state, n_state;
    t_opcode         r_op;
    logic [2:0]      r_islot;
    logic [TW-1:0]   r_now;
    logic [TW-1:0]   r_ivl_in, r_dur_in, r_ofs_in;
    logic            r_rep_in;
    logic [7:0]      r_permit;
    logic [SW:0]     r_idx, n_idx;
    logic [TW-1:0]   r_ran;
    logic            r_flag, n_flag;
    logic [2:0]      r_ev, n_ev;
    logic            r_ok;

    logic            r_ovalid;
    logic [1:0]      r_ores;
    logic [2:0]      r_oslot;
    logic            r_ook, r_olast;

    logic [SW-1:0]   w_i;
    logic [TW-1:0]   w_a, w_b, w_diff;
    logic            w_lt;
    logic            w_permit;
    logic            w_inrange;
    logic [SW-1:0]   w_cs;
    logic            w_out_free;
    logic            w_push;
    logic [1:0]      w_pres;
    logic            w_plast;

    assign w_i = r_idx[SW-1:0];
    assign w_inrange = ({29'd0, r_islot} < NUM_SLOTS);
    assign w_cs = SW'(r_islot);
    assign w_permit = (int'(r_idx) < 8) ? r_permit[3'(r_idx)] : 1'b0;
    assign w_out_free = !r_ovalid || i_ready;

    // shared subtract / compare unit
    always_comb begin
        w_a = r_now;
        w_b = r_stopt[w_i];
        case (r_state)
            ST_IVL: begin
                w_a = r_now;
                w_b = r_stopt[w_i];
            end
            ST_RAN: begin
                w_a = r_now;
                w_b = r_start[w_i];
            end
            ST_OFS: begin
                w_a = r_ofs[w_i];
                w_b = r_ran;
            end
            ST_DUR: begin
                w_a = r_ran;
                w_b = r_dur[w_i];
            end
            default: begin
                w_a = r_now;
                w_b = r_stopt[w_i];
            end
        endcase
    end
    assign w_diff = w_a - w_b;
    assign w_lt = (w_a < w_b);

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_flag = r_flag;
        n_ev = r_ev;
        w_push = 1'b0;
        w_pres = EV_DONE;
        w_plast = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_idx = '0;
                n_state = (r_op == OP_TICK) ? ST_IVL : ST_CMD;
            end
            ST_CMD: begin
                n_state = ST_DONE;
            end
            ST_IVL: begin
                n_ev = '0;
                if (r_phase[w_i] == PH_IDLE) begin
                    n_state = ST_NEXT;
                end else begin
                    n_flag = !r_stopf[w_i] && r_phase[w_i] != PH_RUN && w_permit;
                    if (r_ivl[w_i] != '0 && r_stopt[w_i] != '0 && w_diff < r_ivl[w_i])
                        n_flag = 1'b0;
                    n_state = ST_RAN;
                end
            end
            ST_RAN: begin
                if (r_flag) begin
                    n_ev = 3'b001;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_OFS;
                end
            end
            ST_OFS: begin
                if (r_phase[w_i] == PH_RUN && w_lt) n_ev = 3'b010;
                n_state = ST_DUR;
            end
            ST_DUR: begin
                if (r_stopf[w_i] || (r_phase[w_i] == PH_RUN && r_dur[w_i] != '0
                        && r_start[w_i] != '0 && !w_lt))
                    n_ev = r_ev | 3'b100;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_ev == '0) begin
                    n_state = ST_NEXT;
                end else if (w_out_free) begin
                    w_push = 1'b1;
                    if (r_ev[0]) begin
                        w_pres = EV_START;
                        n_ev = r_ev & 3'b110;
                    end else if (r_ev[1]) begin
                        w_pres = EV_TICK;
                        n_ev = r_ev & 3'b101;
                    end else begin
                        w_pres = EV_STOP;
                        n_ev = '0;
                    end
                end
            end
            ST_NEXT: begin
                if (r_idx == (SW+1)'(NUM_SLOTS - 1)) begin
                    n_idx = '0;
                    n_state = ST_CLEAR;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = ST_IVL;
                end
            end
            ST_CLEAR: begin
                if (r_idx == (SW+1)'(NUM_SLOTS - 1)) n_state = ST_DONE;
                else n_idx = r_idx + 1'b1;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_push = 1'b1;
                    w_pres = EV_DONE;
                    w_plast = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_idx <= '0;
            r_flag <= 1'b0;
            r_ev <= '0;
            r_ok <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_phase[k] <= PH_IDLE;
                r_stopf[k] <= 1'b0;
                r_rep[k] <= 1'b0;
                r_clr[k] <= 1'b0;
                r_ivl[k] <= '0;
                r_dur[k] <= '0;
                r_ofs[k] <= '0;
                r_start[k] <= '0;
                r_stopt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_flag <= n_flag;
            r_ev <= n_ev;
            if (w_push) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (r_state == ST_LOAD) r_ok <= (r_op == OP_TICK);
            if (r_state == ST_CMD && w_inrange) begin
                case (r_op)
                    OP_SCHED: begin
                        if (r_phase[w_cs] == PH_IDLE) begin
                            r_ivl[w_cs] <= r_ivl_in;
                            r_dur[w_cs] <= r_dur_in;
                            r_ofs[w_cs] <= r_ofs_in;
                            r_rep[w_cs] <= r_rep_in;
                            r_phase[w_cs] <= PH_SCHED;
                            r_ok <= 1'b1;
                        end
                    end
                    OP_DESCH: begin
                        if (r_phase[w_cs] != PH_IDLE && r_phase[w_cs] != PH_RUN) begin
                            r_phase[w_cs] <= PH_IDLE;
                            r_ok <= 1'b1;
                        end
                    end
                    OP_STOP: begin
                        if (r_phase[w_cs] != PH_IDLE) begin
                            r_stopf[w_cs] <= 1'b1;
                            r_ok <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == ST_IVL) r_clr[w_i] <= 1'b0;
            if (r_state == ST_RAN) r_ran <= w_diff;
            if (r_state == ST_EMIT && w_push) begin
                if (w_pres == EV_START) begin
                    r_phase[w_i] <= PH_RUN;
                    r_start[w_i] <= r_now;
                end else if (w_pres == EV_STOP) begin
                    r_stopt[w_i] <= r_now;
                    r_phase[w_i] <= PH_PEND;
                    r_clr[w_i] <= !r_rep[w_i];
                    r_stopf[w_i] <= 1'b0;
                end
            end
            if (r_state == ST_CLEAR && r_clr[w_i] && r_phase[w_i] != PH_RUN) begin
                r_phase[w_i] <= PH_IDLE;
            end
            if (r_state == ST_CLEAR) r_clr[w_i] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op <= t_opcode'(i_opcode);
            r_islot <= i_slot;
            r_now <= TW'(i_now);
            r_ivl_in <= TW'(i_interval);
            r_dur_in <= TW'(i_duration);
            r_ofs_in <= TW'(i_tick_after);
            r_rep_in <= i_repeat_req;
            r_permit <= i_permit_mask;
        end
        if (w_push) begin
            r_ores <= w_pres;
            r_oslot <= w_plast ? ((r_op == OP_TICK) ? 3'd0 : r_islot) : 3'(w_i);
            r_ook <= w_plast ? r_ok : 1'b0;
            r_olast <= w_plast;
        end
    end

    assign o_valid = r_ovalid;
    assign o_event_res = r_ores;
    assign o_event_slot = r_oslot;
    assign o_ok = r_ook;
    assign o_last = r_olast;
endmodule
`default_nettype wire

@@ rtl/tass_checker.sv @@
// Checker: port-level assertions for the timed action slot scheduler.
`timescale 1ns / 1ps
`default_nettype none
module tass_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [1:0] o_event_res,
    input wire logic       o_ok,
    input wire logic       o_last
);
    import tass_pkg::*;

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_event_res == EV_DONE))) else $error("last mismatch");
    a_ok_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> !o_ok) else $error("ok on event");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> !o_ready) else $error("ready while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_event_res))) else $error("hold");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("back to back");
endmodule

bind timed_action_slot_scheduler tass_checker u_tass_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_event_res(o_event_res),
    .o_ok(o_ok), .o_last(o_last)
);
`default_nettype wire
